[rtl/core/gacr_pkg.sv]
// Shared types, constants and register codes for the grid-aware charge
// current regulator. No dependencies; every other file imports this package.
package gacr_pkg;

  // Phases taken into the three-phase minimum (1 to 3).
  localparam int PHASE_COUNT = 3;
  localparam int PHASE_MAX   = 3;

  localparam int CUR_W    = 7;
  localparam int TIME_W   = 32;
  localparam int POWER_W  = 16;
  localparam int AVAIL_W  = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  // Register reset values
  localparam logic [CUR_W-1:0]          RST_MIN_CURRENT   = 7'd6;
  localparam logic [CUR_W-1:0]          RST_MAX_CURRENT   = 7'd32;
  localparam logic [CUR_W-1:0]          RST_BIG_GAP       = 7'd5;
  localparam logic signed [AVAIL_W-1:0] RST_NULL_GAP      = 8'sd0;
  localparam logic [CUR_W-1:0]          RST_LIMIT_CURRENT = 7'd32;
  localparam logic [MODE_W-1:0]         RST_GRID_MODE     = 2'd0;
  localparam logic [TIME_W-1:0]         RST_INC_WAIT      = 32'd10000;
  localparam logic [TIME_W-1:0]         RST_DEC_WAIT      = 32'd1000;

  // Grid modes: bit 1 set selects solar, whatever bit 0 holds
  localparam logic [MODE_W-1:0] GRID_PHASE_MIN = 2'd1;
  localparam int                GRID_SOLAR_BIT = 1;

  // Solar quotient: power / 200 as (power * recip) >> shift, exact for
  // every power below the saturation point 128 * 200.
  localparam logic [POWER_W-1:0] SOLAR_SAT_POWER = 16'd25600;
  localparam logic [31:0]        SOLAR_RECIP     = 32'd41944;
  localparam int                 SOLAR_SHIFT     = 23;
  localparam logic signed [AVAIL_W-1:0] SOLAR_SAT = 8'sd127;

  // Step sizes
  localparam logic [CUR_W:0] STEP_SMALL = 8'd1;
  localparam logic [CUR_W:0] STEP_LARGE = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CURRENT   = 3'd0,
    CFG_MAX_CURRENT   = 3'd1,
    CFG_BIG_GAP       = 3'd2,
    CFG_NULL_GAP      = 3'd3,
    CFG_LIMIT_CURRENT = 3'd4,
    CFG_GRID_MODE     = 3'd5,
    CFG_INC_WAIT      = 3'd6,
    CFG_DEC_WAIT      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CUR_W-1:0]          min_current;
    logic [CUR_W-1:0]          max_current;
    logic [CUR_W-1:0]          big_gap;
    logic signed [AVAIL_W-1:0] null_gap;
    logic [CUR_W-1:0]          limit_current;
    logic [MODE_W-1:0]         grid_mode;
    logic [TIME_W-1:0]         increase_wait_ms;
    logic [TIME_W-1:0]         decrease_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]                now_ms;
    logic [PHASE_MAX-1:0][CUR_W-1:0] phase_draw;   // [0] is phase one
    logic [CUR_W-1:0]                 meter_max;
    logic [POWER_W-1:0]               injected_power;
    logic                             link_up;
    logic                             charge_active;
  } item_t;

  typedef struct packed {
    logic [CUR_W-1:0]  setpoint;
    logic [TIME_W-1:0] last_raise_time;
    logic [TIME_W-1:0] last_lower_time;
  } state_t;

endpackage

[rtl/core/gacr_avail.sv]
// Available grid current from one meter item: single phase, phase minimum
// or solar. Depends on gacr_pkg.
module gacr_avail import gacr_pkg::*; (
  input  cfg_t                       cfg,
  input  item_t                      item,
  output logic signed [AVAIL_W-1:0]  avail
);

  logic signed [AVAIL_W:0]   diff [PHASE_MAX];
  logic signed [AVAIL_W:0]   best;
  logic [31:0]               prod;
  logic [CUR_W-1:0]          quot;
  logic signed [AVAIL_W-1:0] solar;

  always_comb begin
    for (int p = 0; p < PHASE_MAX; p++) begin
      diff[p] = $signed({2'b00, item.meter_max}) - $signed({2'b00, item.phase_draw[p]});
    end
    best = diff[0];
    if (cfg.grid_mode == GRID_PHASE_MIN) begin
      for (int p = 1; p < PHASE_COUNT; p++) begin
        if (diff[p] < best) begin
          best = diff[p];
        end
      end
    end
  end

  // divide by 200 through the reciprocal; only used below saturation
  assign prod = {16'd0, item.injected_power} * SOLAR_RECIP;
  assign quot = prod[SOLAR_SHIFT +: CUR_W];

  always_comb begin
    if (item.phase_draw[0] != '0) begin
      solar = -$signed({1'b0, item.phase_draw[0]});
    end else if (item.injected_power >= SOLAR_SAT_POWER) begin
      solar = SOLAR_SAT;
    end else begin
      solar = $signed({1'b0, quot});
    end
  end

  assign avail = cfg.grid_mode[GRID_SOLAR_BIT] ? solar : best[AVAIL_W-1:0];

endmodule

[rtl/core/gacr_step.sv]
// Set-point band decision, rate-limit timers and ceiling clamps for one
// item. Depends on gacr_pkg.
module gacr_step import gacr_pkg::*; (
  input  cfg_t                       cfg,
  input  item_t                      item,
  input  logic signed [AVAIL_W-1:0]  avail,
  input  state_t                     state,
  output state_t                     state_nxt
);

  logic signed [AVAIL_W:0] a9, gap9, ngap9;
  logic [TIME_W-1:0]       up_elapsed, down_elapsed;
  logic                    raise_ok, lower_ok;
  logic [CUR_W:0]          sp, sp_lim, sp_met, sp_max;

  assign a9    = {avail[AVAIL_W-1], avail};
  assign gap9  = $signed({2'b00, cfg.big_gap});
  assign ngap9 = {cfg.null_gap[AVAIL_W-1], cfg.null_gap};

  // wrapping elapsed time since each last step
  assign up_elapsed   = item.now_ms - state.last_raise_time;
  assign down_elapsed = item.now_ms - state.last_lower_time;
  assign raise_ok     = up_elapsed >= cfg.increase_wait_ms;
  assign lower_ok     = down_elapsed >= cfg.decrease_wait_ms;

  always_comb begin
    sp                        = {1'b0, state.setpoint};
    state_nxt.last_raise_time = state.last_raise_time;
    state_nxt.last_lower_time = state.last_lower_time;
    if (a9 < -gap9) begin
      sp = {1'b0, cfg.min_current};
    end else if (a9 < ngap9) begin
      if (state.setpoint > cfg.min_current && lower_ok) begin
        sp                        = {1'b0, state.setpoint} - STEP_SMALL;
        state_nxt.last_lower_time = item.now_ms;
      end
    end else if (a9 == ngap9) begin
      sp = {1'b0, state.setpoint};
    end else if (a9 < gap9) begin
      if (state.setpoint < cfg.max_current && raise_ok) begin
        sp                        = {1'b0, state.setpoint} + STEP_SMALL;
        state_nxt.last_raise_time = item.now_ms;
      end
    end else if (raise_ok) begin
      sp                        = {1'b0, state.setpoint} + STEP_LARGE;
      state_nxt.last_raise_time = item.now_ms;
    end

    // ceilings: user limit, meter maximum when known, vehicle maximum
    sp_lim = (sp > {1'b0, cfg.limit_current}) ? {1'b0, cfg.limit_current} : sp;
    sp_met = (item.meter_max != '0 && sp_lim > {1'b0, item.meter_max}) ?
             {1'b0, item.meter_max} : sp_lim;
    sp_max = (sp_met > {1'b0, cfg.max_current}) ? {1'b0, cfg.max_current} : sp_met;

    if (item.link_up && item.charge_active) begin
      state_nxt.setpoint = sp_max[CUR_W-1:0];
    end else begin
      state_nxt.setpoint        = state.setpoint;
      state_nxt.last_raise_time = state.last_raise_time;
      state_nxt.last_lower_time = state.last_lower_time;
    end
  end

endmodule

[rtl/core/grid_aware_charge_current_regulator.sv]
// Grid-aware charge current regulator: top level with configuration
// registers, input register, regulator state and result register.
// Depends on gacr_pkg, gacr_avail and gacr_step.
//
// One meter item goes in per clock while the output is not stalled, and one
// result comes out per item. The rate is set by the regulator state
// (set-point and both step timers), which is read and rewritten in the
// single cycle that moves an item from the input register to the result
// register; the next item sees the updated state. A stalled result holds
// in the output register while one more item waits in the input register.
// No clearing pass after reset. Configuration registers take writes at any
// time (cfg_ready is always high) and should be written only while the
// block is idle.
module grid_aware_charge_current_regulator import gacr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // meter items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_ms[31:0], phase_one_draw[38:32], phase_two_draw[45:39],
  // phase_three_draw[52:46], meter_max[59:53], injected_power[75:60],
  // link_up[76], charge_active[77], zero[79:78]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // charge_setpoint[6:0], grid_available[14:7], zero[15]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cfg_t                      cfg_r;
  item_t                     item_r;
  logic                      item_valid_r;
  state_t                    state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CUR_W-1:0]          sp_out_r;
  logic signed [AVAIL_W-1:0] avail_out_r;
  logic signed [AVAIL_W-1:0] avail;
  item_t                     in_item;
  logic                      advance, fire;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_current      <= RST_MIN_CURRENT;
      cfg_r.max_current      <= RST_MAX_CURRENT;
      cfg_r.big_gap          <= RST_BIG_GAP;
      cfg_r.null_gap         <= RST_NULL_GAP;
      cfg_r.limit_current    <= RST_LIMIT_CURRENT;
      cfg_r.grid_mode        <= RST_GRID_MODE;
      cfg_r.increase_wait_ms <= RST_INC_WAIT;
      cfg_r.decrease_wait_ms <= RST_DEC_WAIT;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_CURRENT:   cfg_r.min_current      <= cfg_data[CUR_W-1:0];
        CFG_MAX_CURRENT:   cfg_r.max_current      <= cfg_data[CUR_W-1:0];
        CFG_BIG_GAP:       cfg_r.big_gap          <= cfg_data[CUR_W-1:0];
        CFG_NULL_GAP:      cfg_r.null_gap         <= $signed(cfg_data[AVAIL_W-1:0]);
        CFG_LIMIT_CURRENT: cfg_r.limit_current    <= cfg_data[CUR_W-1:0];
        CFG_GRID_MODE:     cfg_r.grid_mode        <= cfg_data[MODE_W-1:0];
        CFG_INC_WAIT:      cfg_r.increase_wait_ms <= cfg_data[TIME_W-1:0];
        CFG_DEC_WAIT:      cfg_r.decrease_wait_ms <= cfg_data[TIME_W-1:0];
      endcase
    end
  end

  // ---- input unpacking ----
  assign in_item.now_ms         = in_tdata[31:0];
  assign in_item.phase_draw[0]  = in_tdata[38:32];
  assign in_item.phase_draw[1]  = in_tdata[45:39];
  assign in_item.phase_draw[2]  = in_tdata[52:46];
  assign in_item.meter_max      = in_tdata[59:53];
  assign in_item.injected_power = in_tdata[75:60];
  assign in_item.link_up        = in_tdata[76];
  assign in_item.charge_active  = in_tdata[77];

  // ---- flow control ----
  // the input register empties whenever the result register can take a value
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || advance;
  assign fire      = item_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  // ---- datapath ----
  gacr_avail u_avail (
    .cfg   (cfg_r),
    .item  (item_r),
    .avail (avail)
  );

  gacr_step u_step (
    .cfg       (cfg_r),
    .item      (item_r),
    .avail     (avail),
    .state     (state_r),
    .state_nxt (state_nxt)
  );

  // regulator state moves only when an item is committed to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.setpoint        <= RST_MIN_CURRENT;
      state_r.last_raise_time <= '0;
      state_r.last_lower_time <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // ---- result register ----
  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sp_out_r    <= state_nxt.setpoint;
      avail_out_r <= avail;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, avail_out_r, sp_out_r};

endmodule

[rtl/core/gacr_checker.sv]
// Port-level checks for the grid-aware charge current regulator, bound to
// the top level. Depends on gacr_pkg.
module gacr_checker import gacr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a taking sink never blocks the source
  a_ready_pass: assert property (@(posedge clk)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

  // available current never reaches the most negative code
  a_avail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:7] != 8'h80)
    else $error("grid_available out of range");

  // a result appearing from empty comes from an item accepted by the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching item");

endmodule

bind grid_aware_charge_current_regulator gacr_checker u_checker (.*);

[bench/gacr_setpoint_checker.sv]
// Scoreboard for the grid-aware charge current regulator: watches the
// configuration, meter and result channels, predicts each result and compares.
// Depends on gacr_pkg for widths, register codes and reset values.
module gacr_setpoint_checker import gacr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int VA_PER_AMP = 200;
  localparam int SOLAR_CAP  = 127;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [CUR_W-1:0]          setpoint;
    logic signed [AVAIL_W-1:0] avail;
  } setpoint_result_t;

  cfg_t              regs;
  logic [CUR_W-1:0]  sp_q;
  logic [TIME_W-1:0] raised_at;
  logic [TIME_W-1:0] lowered_at;
  setpoint_result_t  awaited_setpoints[$];
  int                fails = 0;

  // Next set-point and grid margin for one meter item; updates the state copy.
  function automatic setpoint_result_t regulate(logic [IN_DATA_W-1:0] d);
    item_t             m;
    setpoint_result_t  res;
    int                avail;
    int                gap;
    int                nul;
    int                sp;
    logic [TIME_W-1:0] since_raise;
    logic [TIME_W-1:0] since_lower;
    m.now_ms         = d[31:0];
    m.phase_draw[0]  = d[38:32];
    m.phase_draw[1]  = d[45:39];
    m.phase_draw[2]  = d[52:46];
    m.meter_max      = d[59:53];
    m.injected_power = d[75:60];
    m.link_up        = d[76];
    m.charge_active  = d[77];

    if (regs.grid_mode[GRID_SOLAR_BIT]) begin
      if (m.phase_draw[0] == '0) begin
        avail = int'(m.injected_power) / VA_PER_AMP;
        if (avail > SOLAR_CAP) avail = SOLAR_CAP;
      end else begin
        avail = -int'(m.phase_draw[0]);
      end
    end else begin
      avail = int'(m.meter_max) - int'(m.phase_draw[0]);
      if (regs.grid_mode == GRID_PHASE_MIN) begin
        for (int p = 1; p < PHASE_COUNT; p++) begin
          if (int'(m.meter_max) - int'(m.phase_draw[p]) < avail)
            avail = int'(m.meter_max) - int'(m.phase_draw[p]);
        end
      end
    end

    gap         = int'(regs.big_gap);
    nul         = int'($signed(regs.null_gap));
    sp          = int'(sp_q);
    since_raise = m.now_ms - raised_at;
    since_lower = m.now_ms - lowered_at;
    if (m.link_up && m.charge_active) begin
      if (avail < -gap) begin
        sp = int'(regs.min_current);
      end else if (avail < nul) begin
        if (sp > int'(regs.min_current) && since_lower >= regs.decrease_wait_ms) begin
          sp         = sp - 1;
          lowered_at = m.now_ms;
        end
      end else if (avail == nul) begin
        // hold
      end else if (avail < gap) begin
        if (sp < int'(regs.max_current) && since_raise >= regs.increase_wait_ms) begin
          sp        = sp + 1;
          raised_at = m.now_ms;
        end
      end else if (since_raise >= regs.increase_wait_ms) begin
        sp        = sp + 4;
        raised_at = m.now_ms;
      end
      if (sp > int'(regs.limit_current)) sp = int'(regs.limit_current);
      if (m.meter_max != '0 && sp > int'(m.meter_max)) sp = int'(m.meter_max);
      if (sp > int'(regs.max_current)) sp = int'(regs.max_current);
    end
    sp_q         = sp[CUR_W-1:0];
    res.setpoint = sp_q;
    res.avail    = avail[AVAIL_W-1:0];
    return res;
  endfunction

  task automatic flag_result(input string what, input setpoint_result_t want,
                             input logic [OUT_DATA_W-1:0] got);
    fails++;
    if (fails <= REPORT_MAX)
      $display("%s: setpoint exp %0d got %0d, grid_available exp %0d got %0d",
               what, want.setpoint, got[6:0], want.avail, $signed(got[14:7]));
  endtask

  always @(posedge clk) begin : watch
    setpoint_result_t want;
    if (!rst_n) begin
      regs.min_current      = RST_MIN_CURRENT;
      regs.max_current      = RST_MAX_CURRENT;
      regs.big_gap          = RST_BIG_GAP;
      regs.null_gap         = RST_NULL_GAP;
      regs.limit_current    = RST_LIMIT_CURRENT;
      regs.grid_mode        = RST_GRID_MODE;
      regs.increase_wait_ms = RST_INC_WAIT;
      regs.decrease_wait_ms = RST_DEC_WAIT;
      sp_q       = RST_MIN_CURRENT;
      raised_at  = '0;
      lowered_at = '0;
      awaited_setpoints.delete();
    end else begin
      // compare before queueing, so a result never meets its own item
      if (out_tvalid && out_tready) begin
        if (awaited_setpoints.size() == 0) begin
          want = '0;
          flag_result("result with nothing awaited", want, out_tdata);
        end else begin
          want = awaited_setpoints.pop_front();
          if (out_tdata[6:0] !== want.setpoint || out_tdata[14:7] !== want.avail)
            flag_result("mismatch", want, out_tdata);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_CURRENT:   regs.min_current      = cfg_data[CUR_W-1:0];
          CFG_MAX_CURRENT:   regs.max_current      = cfg_data[CUR_W-1:0];
          CFG_BIG_GAP:       regs.big_gap          = cfg_data[CUR_W-1:0];
          CFG_NULL_GAP:      regs.null_gap         = cfg_data[AVAIL_W-1:0];
          CFG_LIMIT_CURRENT: regs.limit_current    = cfg_data[CUR_W-1:0];
          CFG_GRID_MODE:     regs.grid_mode        = cfg_data[MODE_W-1:0];
          CFG_INC_WAIT:      regs.increase_wait_ms = cfg_data;
          CFG_DEC_WAIT:      regs.decrease_wait_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_setpoints.push_back(regulate(in_tdata));
    end
    pending    <= awaited_setpoints.size();
    fail_count <= fails;
  end

endmodule

[bench/grid_aware_charge_current_regulator_tb.sv]
// Top of the regulator bench: clock, reset, meter and configuration stimulus,
// result back-pressure and the verdict. Depends on gacr_pkg, the regulator RTL
// and gacr_setpoint_checker, which does all prediction and comparison.
module grid_aware_charge_current_regulator_tb;
  import gacr_pkg::*;

  localparam int STALL_LIMIT   = 5000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 118;
  localparam int HOLD_OFF      = 250;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  // now_ms[31:0], phase_one_draw[38:32], phase_two_draw[45:39],
  // phase_three_draw[52:46], meter_max[59:53], injected_power[75:60],
  // link_up[76], charge_active[77], zero[79:78]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // charge_setpoint[6:0], grid_available[14:7], zero[15]
  logic [OUT_DATA_W-1:0] out_tdata;

  int                fail_count;
  int                pending;
  int                hold_cycles = 0;  // set by the stimulus, counted down by the receiver
  int                idle_run = 0;
  int                burst_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  grid_aware_charge_current_regulator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gacr_setpoint_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: the run is stuck if no channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_run, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Result side back-pressure. Styles are drawn at random: always ready,
  // coin toss, mostly stalled, or a fixed duty cycle. A hold-off request
  // from the stimulus overrides all of them.
  initial begin : receiver
    int cnt;
    int style;
    cnt        = 0;
    style      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready  = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        if (cnt == 0) begin
          style = $urandom_range(0, 3);
          cnt   = $urandom_range(20, 120);
        end
        cnt = cnt - 1;
        case (style)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = (cnt % 8) < 5;
        endcase
      end
    end
  end

  function automatic logic [CUR_W-1:0] amps(input int v);
    return (v < 0) ? '0 : (v > 127) ? 7'd127 : v[CUR_W-1:0];
  endfunction

  // Mostly random within the range, with each end taken now and then.
  function automatic int pick_range(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [TIME_W-1:0] random_wait_ms();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return $urandom_range(1, 500);
      2:       return $urandom_range(500, 5000);
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t make_settings(input int mn, input int mx, input int gap,
                                         input int nul, input int lim, input int mode,
                                         input logic [TIME_W-1:0] inc,
                                         input logic [TIME_W-1:0] dec);
    cfg_t s;
    s.min_current      = CUR_W'(mn);
    s.max_current      = CUR_W'(mx);
    s.big_gap          = CUR_W'(gap);
    s.null_gap         = AVAIL_W'(nul);
    s.limit_current    = CUR_W'(lim);
    s.grid_mode        = MODE_W'(mode);
    s.increase_wait_ms = inc;
    s.decrease_wait_ms = dec;
    return s;
  endfunction

  // Drop valid for a number of falling edges (zero leaves it as it is).
  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
  endtask

  // Stop sending, wait for every awaited result, then let the pipe run dry.
  task automatic settle();
    idle_input(1);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // All eight registers every time; only called with the block idle.
  task automatic apply_settings(input cfg_t s);
    write_reg(CFG_MIN_CURRENT,   CFG_DATA_W'(s.min_current));
    write_reg(CFG_MAX_CURRENT,   CFG_DATA_W'(s.max_current));
    write_reg(CFG_BIG_GAP,       CFG_DATA_W'(s.big_gap));
    write_reg(CFG_NULL_GAP,      CFG_DATA_W'(s.null_gap[AVAIL_W-1:0]));
    write_reg(CFG_LIMIT_CURRENT, CFG_DATA_W'(s.limit_current));
    write_reg(CFG_GRID_MODE,     CFG_DATA_W'(s.grid_mode));
    write_reg(CFG_INC_WAIT,      s.increase_wait_ms);
    write_reg(CFG_DEC_WAIT,      s.decrease_wait_ms);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one meter item and wait for the edge that takes it. Valid is left
  // high so a back-to-back item follows without a bubble.
  task automatic send_meter(input item_t m);
    @(negedge clk);
    in_tdata  = {2'b00, m.charge_active, m.link_up, m.injected_power, m.meter_max,
                 m.phase_draw[2], m.phase_draw[1], m.phase_draw[0], m.now_ms};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_reading(input logic [TIME_W-1:0] now, input int p1, input int p2,
                              input int p3, input int mm, input int inj,
                              input int link, input int act);
    item_t m;
    m.now_ms         = now;
    m.phase_draw[0]  = CUR_W'(p1);
    m.phase_draw[1]  = CUR_W'(p2);
    m.phase_draw[2]  = CUR_W'(p3);
    m.meter_max      = CUR_W'(mm);
    m.injected_power = POWER_W'(inj);
    m.link_up        = link[0];
    m.charge_active  = act[0];
    send_meter(m);
  endtask

  initial begin : stimulus
    cfg_t  s;
    item_t m;
    int    roll;
    int    target;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_CURRENT;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- Directed: single phase, timers open ---
    apply_settings(make_settings(6, 32, 5, 0, 32, 0, 0, 0));
    send_reading(0, 0, 0, 0, 127, 0, 1, 1);                  // widest surplus, +4
    send_reading(1, 127, 127, 127, 0, 16'hFFFF, 0, 1);       // link down: no move
    send_reading(2, 127, 127, 127, 0, 0, 1, 0);              // charge inactive
    send_reading(3, 37, 0, 0, 40, 0, 1, 1);                  // small surplus, +1
    send_reading(4, 40, 0, 0, 40, 0, 1, 1);                  // exactly on null: hold
    send_reading(5, 42, 0, 0, 40, 0, 1, 1);                  // small deficit, -1
    send_reading(6, 50, 0, 0, 40, 0, 1, 1);                  // large deficit: minimum
    send_reading(7, 45, 0, 0, 40, 0, 1, 1);                  // small deficit at minimum
    send_reading(8, 0, 0, 0, 10, 0, 1, 1);                   // +4 lands on the meter maximum
    send_reading(32'hFFFF_FFFF, 0, 0, 0, 40, 0, 1, 1);       // top of the time range
    settle();

    // --- Directed: three-phase minimum, rate limits that bite ---
    apply_settings(make_settings(6, 20, 5, 0, 18, 1, 1000, 500));
    send_reading(100, 10, 30, 20, 40, 0, 1, 1);              // wrapped interval, too soon
    send_reading(2000, 10, 30, 20, 40, 0, 1, 1);             // +4 lands on the limit
    send_reading(3100, 10, 3, 37, 40, 0, 1, 1);              // phase three sets the margin
    send_reading(3200, 45, 50, 41, 40, 0, 1, 1);             // large deficit: minimum
    settle();

    // --- Directed: solar, minimum above maximum ---
    apply_settings(make_settings(40, 20, 5, 0, 100, 2, 0, 0));
    send_reading(10, 0, 127, 127, 0, 0, 1, 1);               // no export: zero margin
    send_reading(11, 0, 0, 0, 0, 199, 1, 1);                 // just below one amp
    send_reading(12, 0, 0, 0, 0, 200, 1, 1);                 // one amp
    send_reading(13, 0, 0, 0, 0, 25599, 1, 1);               // last unsaturated quotient
    send_reading(14, 0, 0, 0, 0, 25600, 1, 1);               // saturates
    send_reading(15, 5, 0, 0, 0, 16'hFFFF, 1, 1);            // drawing: power ignored
    send_reading(16, 127, 0, 0, 0, 0, 1, 1);                 // drop to minimum, then max clamp
    settle();

    // --- Directed: mode three acts as solar; bands overlap at the extremes ---
    apply_settings(make_settings(0, 100, 127, -127, 100, 3, 0, 0));
    send_reading(20, 0, 0, 0, 127, 16'hFFFF, 1, 1);
    send_reading(21, 1, 0, 0, 127, 0, 1, 1);
    send_reading(22, 127, 0, 0, 127, 0, 1, 1);
    settle();

    // --- Random phases, each with its own register settings ---
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        s = make_settings(6, 32, 5, 0, 32, 0, 10000, 1000);  // power-on values
      end else if (ph == 6) begin
        s = make_settings(100, 100, 127, 127, 100, $urandom_range(0, 3),
                          random_wait_ms(), random_wait_ms());
      end else if (ph == 7) begin
        s = make_settings(0, 0, 0, -127, 0, $urandom_range(0, 3),
                          random_wait_ms(), random_wait_ms());
      end else begin
        s = make_settings(pick_range(0, 100), pick_range(0, 100), pick_range(0, 127),
                          pick_range(-127, 127), pick_range(0, 100), $urandom_range(0, 3),
                          random_wait_ms(), random_wait_ms());
      end
      settle();
      apply_settings(s);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bursts of back-to-back items with gaps between them
        if (burst_left == 0) begin
          idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        // long receiver hold-off while items keep coming: input must stall
        if (ph == 1 && n == 40) hold_cycles = HOLD_OFF;
        // one mid-phase pause until every result is back
        if (ph == 3 && n == 60) settle();

        clock_ms = clock_ms + (($urandom_range(0, 19) == 0) ? $urandom
                                                            : $urandom_range(0, 2500));
        m.now_ms = clock_ms;
        roll     = $urandom_range(0, 99);
        if (roll < 12) begin
          // noise: any value in every field but the time
          m.phase_draw[0]  = CUR_W'($urandom);
          m.phase_draw[1]  = CUR_W'($urandom);
          m.phase_draw[2]  = CUR_W'($urandom);
          m.meter_max      = CUR_W'($urandom);
          m.injected_power = POWER_W'($urandom);
          m.link_up        = 1'($urandom);
          m.charge_active  = 1'($urandom);
        end else begin
          // regulating: margin lands near the bands around null_gap
          m.link_up        = (roll != 12 && roll != 13);
          m.charge_active  = (roll != 14 && roll != 15);
          m.meter_max      = ($urandom_range(0, 7) == 0) ? '0
                                                         : CUR_W'($urandom_range(10, 100));
          m.injected_power = POWER_W'($urandom);
          m.phase_draw[1]  = CUR_W'($urandom);
          m.phase_draw[2]  = CUR_W'($urandom);
          target = int'($signed(s.null_gap)) + int'($urandom_range(0, 2 * s.big_gap + 6))
                   - int'(s.big_gap) - 3;
          if (s.grid_mode[GRID_SOLAR_BIT]) begin
            if ($urandom_range(0, 2) != 0) begin
              m.phase_draw[0] = '0;
              if ($urandom_range(0, 9) != 0)
                m.injected_power = POWER_W'(int'(amps(target)) * 200 +
                                            int'($urandom_range(0, 199)));
            end else begin
              m.phase_draw[0] = amps(-target);
            end
          end else begin
            m.phase_draw[0] = amps(int'(m.meter_max) - target);
            m.phase_draw[1] = amps(int'(m.phase_draw[0]) + int'($urandom_range(0, 12)) - 6);
            m.phase_draw[2] = amps(int'(m.phase_draw[0]) + int'($urandom_range(0, 12)) - 6);
          end
        end
        send_meter(m);
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
